// File: rtl/b64enc_pkg.sv
// Package for the base64 stream encoder: beat and group types, pad code,
// and the 6-bit to character mapping. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64enc_pkg;

  // Input beat: one raw message byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  // Output beat: one encoded character
  typedef struct packed {
    logic [7:0] out_char;
    logic       run_end;
    logic       message_end;
  } out_item_t;

  // One gathered group, zero-filled, as handed from front to back
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;  // 1 to 3 real bytes
    logic       fin;
  } group_t;

  localparam logic [7:0] PadChar = 8'h3D;

  localparam logic [5:0] UpperEnd = 6'd26;
  localparam logic [5:0] LowerEnd = 6'd52;
  localparam logic [5:0] DigitEnd = 6'd62;
  localparam logic [5:0] PlusCode = 6'd62;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] ve;
    logic [7:0] res;
    ve = {2'b00, v};
    if (v < UpperEnd) begin
      res = 8'h41 + ve;
    end else if (v < LowerEnd) begin
      res = 8'h47 + ve;            // 'a' - 26
    end else if (v < DigitEnd) begin
      res = ve - 8'h04;            // '0' - 52, wraps to the right value
    end else if (v == PlusCode) begin
      res = 8'h2B;
    end else begin
      res = 8'h2F;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/b64enc_front.sv
// Front end: accepts input beats, holds the open group and pushes each
// complete or final group to the queue. Depends on b64enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64enc_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire b64enc_pkg::in_item_t in_data_i,
  output logic                      push_o,
  output b64enc_pkg::group_t        push_data_o,
  input  wire logic                 full_i
);

  logic [1:0] phase_q, phase_d;
  logic [7:0] held_first_q, held_first_d;
  logic [7:0] held_second_q, held_second_d;
  logic       accept;
  logic       hold_only;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  // phase three never occurs; it is taken as phase zero, no bytes held
  assign hold_only  = (phase_q != 2'd2) && !in_data_i.final_byte;
  assign push_o     = accept && !hold_only;

  always_comb begin
    push_data_o.fin    = in_data_i.final_byte;
    push_data_o.b2     = 8'h00;
    push_data_o.b1     = 8'h00;
    push_data_o.b0     = in_data_i.data_byte;
    push_data_o.nbytes = 2'd1;
    case (phase_q)
      2'd1: begin
        push_data_o.b0     = held_first_q;
        push_data_o.b1     = in_data_i.data_byte;
        push_data_o.nbytes = 2'd2;
      end
      2'd2: begin
        push_data_o.b0     = held_first_q;
        push_data_o.b1     = held_second_q;
        push_data_o.b2     = in_data_i.data_byte;
        push_data_o.nbytes = 2'd3;
      end
      default: ;
    endcase
  end

  always_comb begin
    phase_d       = phase_q;
    held_first_d  = held_first_q;
    held_second_d = held_second_q;
    if (accept) begin
      if (hold_only) begin
        if (phase_q == 2'd1) begin
          held_second_d = in_data_i.data_byte;
          phase_d       = 2'd2;
        end else begin
          held_first_d = in_data_i.data_byte;
          phase_d      = 2'd1;
        end
      end else begin
        phase_d       = 2'd0;
        held_first_d  = 8'h00;
        held_second_d = 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= 2'd0;
      held_first_q  <= 8'h00;
      held_second_q <= 8'h00;
    end else begin
      phase_q       <= phase_d;
      held_first_q  <= held_first_d;
      held_second_q <= held_second_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/b64enc_fifo.sv
// Two-entry group queue between front and back end.
// Depends on b64enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64enc_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire b64enc_pkg::group_t push_data_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output b64enc_pkg::group_t      head_o
);

  b64enc_pkg::group_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/b64enc_back.sv
// Back end: walks the queue head one character a cycle while not stalled
// into the output register, padding past real bytes. Depends on b64enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64enc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               empty_i,
  input  wire b64enc_pkg::group_t head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output b64enc_pkg::out_item_t   out_data_o
);

  logic [1:0]            k_q, k_d;
  logic                  out_valid_q, out_valid_d;
  b64enc_pkg::out_item_t out_q;
  logic                  load;
  logic [5:0]            six;
  b64enc_pkg::out_item_t next_item;

  // output register free or draining this cycle
  assign load  = !empty_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load && (k_q == 2'd3);

  always_comb begin
    case (k_q)
      2'd0:    six = head_i.b0[7:2];
      2'd1:    six = {head_i.b0[1:0], head_i.b1[7:4]};
      2'd2:    six = {head_i.b1[3:0], head_i.b2[7:6]};
      default: six = head_i.b2[5:0];
    endcase
    next_item.out_char    = (k_q > head_i.nbytes) ? b64enc_pkg::PadChar
                                                  : b64enc_pkg::sym(six);
    next_item.run_end     = (k_q == 2'd3);
    next_item.message_end = (k_q == 2'd3) && head_i.fin;
  end

  always_comb begin
    k_d         = k_q;
    out_valid_d = out_valid_q;
    if (load) begin
      k_d         = k_q + 2'd1;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= next_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/base64_stream_encoder_unit.sv
// Top level of the base64 stream encoder: front end, group queue and
// back end. Depends on b64enc_pkg and the b64enc_* modules.
`timescale 1ns / 1ps
`default_nettype none

// Encodes a byte stream to standard base64, one input beat per byte and one
// output beat per character. Every third byte, and the final byte of a
// message, closes a group that gives four characters, short groups padded
// with '='; run_end marks the fourth character and message_end also marks it
// on the final group. Bytes are taken one per cycle while the two-entry group
// queue has room; the back end emits one character per cycle while the queue
// is not empty and the output is not stalled, so the stream rate is set by
// the single character path of the back end, and a message's last short
// group still gives four characters. With the queue empty, a group's closing
// byte is written into the queue, and its first character is then loaded
// from the queue head into the output register.

module base64_stream_encoder_unit (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire b64enc_pkg::in_item_t  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output b64enc_pkg::out_item_t      out_data_o
);

  logic               push;
  b64enc_pkg::group_t push_data;
  logic               full;
  logic               pop;
  logic               empty;
  b64enc_pkg::group_t head;

  b64enc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  b64enc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
